/* design/pslz_pkg.sv */
// Shared types, codes and defaults for the packed-section LZ decompressor.
package pslz_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 256;
	localparam logic [7:0]  REF_FLAG          = 8'h80;

	// Section phase; the two copy phases stall the input side.
	typedef enum logic [2:0] {
		PH_HDR_LO,
		PH_HDR_HI,
		PH_CTRL,
		PH_LIT,
		PH_OFFSET,
		PH_DRAIN,
		PH_COPY_RD,
		PH_COPY_WR
	} phase_t;

	// Status codes reported on the end word.
	typedef enum logic [2:0] {
		ST_OK,
		ST_TOO_SHORT,
		ST_LIT_PAST_END,
		ST_OVERSIZE,
		ST_REF_PAST_END,
		ST_BAD_OFFSET
	} stat_t;

	// Where the data bytes of a pushed word come from.
	typedef enum logic [1:0] {
		BSEL_NONE,
		BSEL_LIT,
		BSEL_COPY
	} byte_sel_t;

	// Source of the zero-pad count on an ok end word.
	typedef enum logic [1:0] {
		PAD_REM,
		PAD_REM_M1,
		PAD_HDR
	} pad_sel_t;

	typedef struct packed {
		logic      hdr_lo;
		logic      hdr_hi;
		logic      lit_load;
		logic      ref_load;
		logic      off_load;
		logic      lit_byte;
		logic      copy_rd;
		logic      copy_wr;
		logic      push;
		logic      push_end;
		stat_t     status;
		byte_sel_t byte_sel;
		pad_sel_t  pad_sel;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic byte_zero;
		logic byte_ref;
		logic hdr_len_zero;
		logic ctl_gt_rem;
		logic rem_zero;
		logic rem_one;
		logic lit_last;
		logic off_bad;
		logic copy_zero;
		logic copy_one;
		logic pend;
		logic held_last;
	} sts_t;

endpackage

/* design/pslz_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pslz_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/pslz_ctrl.sv */
// Controller state machine: section phase sequencing and datapath commands.
module pslz_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last_byte,
	input  pslz_pkg::sts_t sts,
	output logic          in_ready,
	output pslz_pkg::cmd_t cmd
);

	pslz_pkg::phase_t phase_q, phase_d;
	logic             acc;

	assign in_ready = (phase_q != pslz_pkg::PH_COPY_RD) && (phase_q != pslz_pkg::PH_COPY_WR) &&
		sts.out_free;
	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pslz_pkg::PH_HDR_LO;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Next state
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			pslz_pkg::PH_COPY_RD: begin
				phase_d = pslz_pkg::PH_COPY_WR;
			end
			pslz_pkg::PH_COPY_WR: begin
				if (sts.out_free) begin
					if (!sts.copy_one) begin
						phase_d = pslz_pkg::PH_COPY_RD;
					end else if (sts.held_last) begin
						phase_d = pslz_pkg::PH_HDR_LO;
					end else if (cmd.push_end) begin
						phase_d = pslz_pkg::PH_DRAIN;
					end else begin
						phase_d = pslz_pkg::PH_CTRL;
					end
				end
			end
			pslz_pkg::PH_OFFSET: begin
				if (acc) begin
					// a valid nonzero copy runs first; the held last flag closes it
					if (!sts.off_bad && !sts.copy_zero) begin
						phase_d = pslz_pkg::PH_COPY_RD;
					end else if (last_byte) begin
						phase_d = pslz_pkg::PH_HDR_LO;
					end else if (cmd.push_end) begin
						phase_d = pslz_pkg::PH_DRAIN;
					end else begin
						phase_d = pslz_pkg::PH_CTRL;
					end
				end
			end
			pslz_pkg::PH_HDR_LO, pslz_pkg::PH_HDR_HI, pslz_pkg::PH_CTRL,
			pslz_pkg::PH_LIT, pslz_pkg::PH_DRAIN: begin
				if (acc) begin
					if (last_byte) begin
						phase_d = pslz_pkg::PH_HDR_LO;
					end else if (cmd.push_end) begin
						phase_d = pslz_pkg::PH_DRAIN;
					end else begin
						unique case (phase_q)
							pslz_pkg::PH_HDR_LO: phase_d = pslz_pkg::PH_HDR_HI;
							pslz_pkg::PH_HDR_HI: phase_d = pslz_pkg::PH_CTRL;
							pslz_pkg::PH_CTRL: begin
								if (sts.byte_ref) begin
									phase_d = pslz_pkg::PH_OFFSET;
								end else if (!sts.byte_zero) begin
									phase_d = pslz_pkg::PH_LIT;
								end else begin
									phase_d = pslz_pkg::PH_CTRL;
								end
							end
							pslz_pkg::PH_LIT: begin
								phase_d = sts.lit_last ? pslz_pkg::PH_CTRL : pslz_pkg::PH_LIT;
							end
							default: phase_d = phase_q;
						endcase
					end
				end
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd          = '0;
		cmd.status   = pslz_pkg::ST_OK;
		cmd.byte_sel = pslz_pkg::BSEL_NONE;
		cmd.pad_sel  = pslz_pkg::PAD_REM;
		unique case (phase_q)
			pslz_pkg::PH_HDR_LO: begin
				if (acc) begin
					cmd.hdr_lo = 1'b1;
					if (last_byte) begin
						cmd.push     = 1'b1;
						cmd.push_end = 1'b1;
						cmd.status   = pslz_pkg::ST_TOO_SHORT;
					end
				end
			end
			pslz_pkg::PH_HDR_HI: begin
				if (acc) begin
					cmd.hdr_hi = 1'b1;
					if (sts.hdr_len_zero || last_byte) begin
						cmd.push     = 1'b1;
						cmd.push_end = 1'b1;
						cmd.pad_sel  = pslz_pkg::PAD_HDR;
					end
				end
			end
			pslz_pkg::PH_CTRL: begin
				if (acc) begin
					if (!sts.byte_ref) begin
						priority if (last_byte && !sts.byte_zero) begin
							cmd.push     = 1'b1;
							cmd.push_end = 1'b1;
							cmd.status   = pslz_pkg::ST_LIT_PAST_END;
						end else if (sts.ctl_gt_rem) begin
							cmd.push     = 1'b1;
							cmd.push_end = 1'b1;
							cmd.status   = pslz_pkg::ST_OVERSIZE;
						end else if (!sts.byte_zero) begin
							cmd.lit_load = 1'b1;
						end else if (last_byte) begin
							cmd.push     = 1'b1;
							cmd.push_end = 1'b1;
						end
					end else begin
						priority if (sts.ctl_gt_rem) begin
							cmd.push     = 1'b1;
							cmd.push_end = 1'b1;
							cmd.status   = pslz_pkg::ST_OVERSIZE;
						end else if (last_byte) begin
							cmd.push     = 1'b1;
							cmd.push_end = 1'b1;
							cmd.status   = pslz_pkg::ST_REF_PAST_END;
						end else begin
							cmd.ref_load = 1'b1;
						end
					end
				end
			end
			pslz_pkg::PH_LIT: begin
				if (acc) begin
					cmd.lit_byte = 1'b1;
					cmd.push     = 1'b1;
					cmd.byte_sel = pslz_pkg::BSEL_LIT;
					cmd.pad_sel  = pslz_pkg::PAD_REM_M1;
					if (sts.lit_last) begin
						cmd.push_end = sts.rem_one || last_byte;
					end else if (last_byte) begin
						cmd.push_end = 1'b1;
						cmd.status   = pslz_pkg::ST_LIT_PAST_END;
					end
				end
			end
			pslz_pkg::PH_OFFSET: begin
				if (acc) begin
					if (sts.off_bad) begin
						cmd.push     = 1'b1;
						cmd.push_end = 1'b1;
						cmd.status   = pslz_pkg::ST_BAD_OFFSET;
					end else begin
						cmd.off_load = 1'b1;
						if (sts.copy_zero && (sts.rem_zero || last_byte)) begin
							cmd.push     = 1'b1;
							cmd.push_end = 1'b1;
						end
					end
				end
			end
			pslz_pkg::PH_DRAIN: begin
				cmd.push = 1'b0;
			end
			pslz_pkg::PH_COPY_RD: begin
				cmd.copy_rd = 1'b1;
			end
			pslz_pkg::PH_COPY_WR: begin
				if (sts.out_free) begin
					cmd.copy_wr  = 1'b1;
					cmd.push     = sts.pend || sts.copy_one;
					cmd.byte_sel = pslz_pkg::BSEL_COPY;
					cmd.pad_sel  = pslz_pkg::PAD_REM_M1;
					cmd.push_end = sts.copy_one && (sts.rem_one || sts.held_last);
				end
			end
		endcase
	end

endmodule

/* design/pslz_dpath.sv */
// Datapath: section counters, history RAM, byte pairing and output register.
module pslz_dpath #(
	parameter int unsigned HISTORY_DEPTH = pslz_pkg::HISTORY_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     packed_byte,
	input  logic           last_byte,
	input  pslz_pkg::cmd_t cmd,
	output pslz_pkg::sts_t sts,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     first_byte,
	output logic [7:0]     second_byte,
	output logic [1:0]     byte_count,
	output logic           end_of_section,
	output logic [2:0]     status,
	output logic [15:0]    pad_zero_count
);

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);
	localparam int unsigned FW = AW + 1;
	localparam logic [FW-1:0] DEPTH_F = FW'(HISTORY_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(HISTORY_DEPTH - 1);

	logic [7:0]    len_low_q;
	logic [15:0]   rem_q;
	logic [6:0]    lit_q;
	logic [6:0]    copy_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] src_q;
	logic [FW-1:0] fill_q;
	logic          pend_q;
	logic [7:0]    pend_byte_q;
	logic          held_last_q;

	logic [7:0]    rdata;
	logic          ram_we;
	logic [7:0]    ram_wdata;
	logic [FW-1:0] diff;
	logic [FW-1:0] diff_wrap;
	logic [AW-1:0] src_start;
	logic [AW-1:0] wp_next;
	logic [AW-1:0] src_next;
	logic [15:0]   hdr_len;
	logic [15:0]   pad_val;
	logic [7:0]    b0;
	logic [7:0]    b1;
	logic [1:0]    cnt;

	assign hdr_len = {packed_byte, len_low_q};

	// start of a copy: write pointer minus offset, modulo history depth
	assign diff      = {1'b0, wp_q} - FW'(packed_byte);
	assign diff_wrap = diff + DEPTH_F;
	assign src_start = ({1'b0, wp_q} >= FW'(packed_byte)) ? diff[AW-1:0] : diff_wrap[AW-1:0];
	assign wp_next   = (wp_q == LAST_A) ? '0 : wp_q + 1'b1;
	assign src_next  = (src_q == LAST_A) ? '0 : src_q + 1'b1;

	assign ram_we    = cmd.lit_byte || cmd.copy_wr;
	assign ram_wdata = cmd.lit_byte ? packed_byte : rdata;

	pslz_ram #(
		.WIDTH (8),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (ram_wdata),
		.re    (cmd.copy_rd),
		.raddr (src_q),
		.rdata (rdata)
	);

	always_comb begin
		sts.out_free     = !out_valid || out_ready;
		sts.byte_zero    = (packed_byte == 8'd0);
		sts.byte_ref     = (packed_byte >= pslz_pkg::REF_FLAG);
		sts.hdr_len_zero = (hdr_len == 16'd0);
		sts.ctl_gt_rem   = ({9'd0, packed_byte[6:0]} > rem_q);
		sts.rem_zero     = (rem_q == 16'd0);
		sts.rem_one      = (rem_q == 16'd1);
		sts.lit_last     = (lit_q == 7'd1);
		sts.off_bad      = (packed_byte == 8'd0) || (FW'(packed_byte) > fill_q);
		sts.copy_zero    = (copy_q == 7'd0);
		sts.copy_one     = (copy_q == 7'd1);
		sts.pend         = pend_q;
		sts.held_last    = held_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_low_q   <= '0;
			rem_q       <= '0;
			lit_q       <= '0;
			copy_q      <= '0;
			wp_q        <= '0;
			src_q       <= '0;
			fill_q      <= '0;
			pend_q      <= 1'b0;
			held_last_q <= 1'b0;
		end else begin
			if (cmd.hdr_lo) begin
				len_low_q <= packed_byte;
				rem_q     <= '0;
				lit_q     <= '0;
				copy_q    <= '0;
				wp_q      <= '0;
				fill_q    <= '0;
			end
			if (cmd.hdr_hi) begin
				rem_q <= hdr_len;
			end
			if (cmd.lit_load) begin
				lit_q <= packed_byte[6:0];
			end
			if (cmd.ref_load) begin
				copy_q <= packed_byte[6:0];
			end
			if (cmd.off_load) begin
				src_q       <= src_start;
				held_last_q <= last_byte;
				pend_q      <= 1'b0;
			end
			if (ram_we) begin
				wp_q  <= wp_next;
				rem_q <= rem_q - 16'd1;
				if (fill_q < DEPTH_F) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.lit_byte) begin
				lit_q <= lit_q - 7'd1;
			end
			if (cmd.copy_wr) begin
				src_q  <= src_next;
				copy_q <= copy_q - 7'd1;
				if (pend_q) begin
					pend_q <= 1'b0;
				end else if (copy_q != 7'd1) begin
					pend_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.copy_wr && !pend_q) begin
			pend_byte_q <= rdata;
		end
	end

	// payload of the word being pushed
	always_comb begin
		unique case (cmd.byte_sel)
			pslz_pkg::BSEL_LIT: begin
				b0  = packed_byte;
				b1  = 8'd0;
				cnt = 2'd1;
			end
			pslz_pkg::BSEL_COPY: begin
				b0  = pend_q ? pend_byte_q : rdata;
				b1  = pend_q ? rdata : 8'd0;
				cnt = pend_q ? 2'd2 : 2'd1;
			end
			default: begin
				b0  = 8'd0;
				b1  = 8'd0;
				cnt = 2'd0;
			end
		endcase
		unique case (cmd.pad_sel)
			pslz_pkg::PAD_REM_M1: pad_val = rem_q - 16'd1;
			pslz_pkg::PAD_HDR:    pad_val = hdr_len;
			default:              pad_val = rem_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.push) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			first_byte     <= b0;
			second_byte    <= b1;
			byte_count     <= cnt;
			end_of_section <= cmd.push_end;
			status         <= cmd.push_end ? cmd.status : pslz_pkg::ST_OK;
			pad_zero_count <= (cmd.push_end && cmd.status == pslz_pkg::ST_OK) ? pad_val : 16'd0;
		end
	end

endmodule

/* design/packed_section_lz_decompressor.sv */
// Top level of the packed-section LZ decompressor.
// Takes one packed byte per input word: two little-endian header bytes with the declared
// output length, then control bytes (below 0x80: literal run of that many bytes; 0x80 and
// above: copy of control-0x80 bytes from the history, offset in the following byte).
// Each output word carries up to two decompressed bytes; every section closes with exactly
// one word flagged end_of_section that holds the status and, when ok, the zero-pad count.
// Header, control, offset and literal bytes are taken one per cycle while the output
// register can take a word. After an offset byte the input is held off for the copy, which
// follows the history RAM's registered read: the copy-read phase reads the source entry,
// then the copy-write phase writes it back at the write pointer and pairs it into an
// output word. The history needs no clearing pass after reset; copies only reach entries
// written earlier in the same section.
module packed_section_lz_decompressor #(
	parameter int unsigned HISTORY_DEPTH = pslz_pkg::HISTORY_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  packed_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  first_byte,
	output logic [7:0]  second_byte,
	output logic [1:0]  byte_count,
	output logic        end_of_section,
	output logic [2:0]  status,
	output logic [15:0] pad_zero_count
);

	pslz_pkg::cmd_t cmd;
	pslz_pkg::sts_t sts;

	// phase sequencing, end/status decisions
	pslz_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_byte (last_byte),
		.sts       (sts),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	// counters, history RAM, pairing and output word register
	pslz_dpath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.packed_byte    (packed_byte),
		.last_byte      (last_byte),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.first_byte     (first_byte),
		.second_byte    (second_byte),
		.byte_count     (byte_count),
		.end_of_section (end_of_section),
		.status         (status),
		.pad_zero_count (pad_zero_count)
	);

	// the input side is shut while a copy reads the history
	a_no_accept_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.copy_rd || cmd.copy_wr) |-> !in_ready)
		else $error("input ready during history copy");

	// a pushed word is visible in the next cycle
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> out_valid)
		else $error("pushed word not presented");

	// an error end word never carries a pad count
	a_err_no_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != pslz_pkg::ST_OK) |-> (end_of_section && pad_zero_count == 16'd0))
		else $error("bad status or pad on output word");

endmodule
